// File: design/aispse_pkg.sv
// ----------------------------------------------------------------------------
// aispse_pkg - shared types and constants for the AIS position sentence encoder
// Holds the sentence template, the cell content type and the character
// helpers that build each byte of the sentence.
// ----------------------------------------------------------------------------
package aispse_pkg;

    localparam int SENT_LEN   = 48;
    localparam int POS_W      = 6;
    localparam int LAT_W      = 27;
    localparam int LON_W      = 28;
    localparam int HDG_W      = 9;
    localparam int CHR_W      = 8;

    localparam logic [POS_W-1:0] ID_POS     = 6'd18;
    localparam logic [POS_W-1:0] STAR_POS   = 6'd44;
    localparam logic [POS_W-1:0] HEX_HI_POS = 6'd45;
    localparam logic [POS_W-1:0] HEX_LO_POS = 6'd46;
    localparam logic [POS_W-1:0] LAST_POS   = 6'd47;

    localparam logic [CHR_W-1:0] CHR_BANG      = 8'h21;
    localparam logic [CHR_W-1:0] CHR_TARGET    = 8'h65;  // 'e'
    localparam logic [CHR_W-1:0] CHR_OWN       = 8'h66;  // 'f'
    localparam logic [5:0]       SIX_MASK      = 6'h3F;
    localparam logic [5:0]       ARMOR_SPLIT   = 6'd39;
    localparam logic [CHR_W-1:0] ARMOR_LO_OFS  = 8'd48;
    localparam logic [CHR_W-1:0] ARMOR_HI_OFS  = 8'd56;
    localparam logic [CHR_W-1:0] HEX_DIG_OFS   = 8'd48;
    localparam logic [CHR_W-1:0] HEX_ALPHA_OFS = 8'd55;

    // Constant characters of the sentence, byte 0 in the top bits.
    localparam logic [8*SENT_LEN-1:0] TEMPLATE =
        "!AIVDM,1,1,,A,13u?ftP00000000000000000069D,0*  \n";

    // Role of each byte as it leaves the head of the chain
    typedef enum logic [2:0] {
        K_PLAIN,
        K_SUM,
        K_HEX_HI,
        K_HEX_LO,
        K_LAST
    } t_kind;

    typedef struct packed {
        logic             vld;
        t_kind            kind;
        logic [CHR_W-1:0] chr;
    } t_cell;

    function automatic logic [CHR_W-1:0] armor6(input logic [5:0] v);
        logic [5:0] m;
        m = v & SIX_MASK;
        return (m > ARMOR_SPLIT) ? ({2'b00, m} + ARMOR_HI_OFS)
                                 : ({2'b00, m} + ARMOR_LO_OFS);
    endfunction

    function automatic logic [CHR_W-1:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? ({4'h0, n} + HEX_DIG_OFS)
                           : ({4'h0, n} + HEX_ALPHA_OFS);
    endfunction

    function automatic t_kind kind_of(input logic [POS_W-1:0] idx);
        t_kind k;
        priority if (idx == '0)             k = K_PLAIN;
        else if (idx < STAR_POS)            k = K_SUM;
        else if (idx == HEX_HI_POS)         k = K_HEX_HI;
        else if (idx == HEX_LO_POS)         k = K_HEX_LO;
        else if (idx == LAST_POS)           k = K_LAST;
        else                                k = K_PLAIN;
        return k;
    endfunction

    // Byte loaded into cell idx for a new position item
    function automatic logic [CHR_W-1:0] load_char(
        input logic [POS_W-1:0] idx,
        input logic [LAT_W-1:0] lat,
        input logic [LON_W-1:0] lon,
        input logic [HDG_W-1:0] hdg,
        input logic             tgt
    );
        logic [CHR_W-1:0] c;
        c = TEMPLATE[8*(SENT_LEN-1-int'(idx)) +: 8];
        unique case (idx)
            ID_POS:  c = tgt ? CHR_TARGET : CHR_OWN;
            6'd24:   c = armor6({1'b0, lon[27:23]});
            6'd25:   c = armor6(lon[22:17]);
            6'd26:   c = armor6(lon[16:11]);
            6'd27:   c = armor6(lon[10:5]);
            6'd28:   c = armor6({lon[4:0], lat[26]});
            6'd29:   c = armor6(lat[25:20]);
            6'd30:   c = armor6(lat[19:14]);
            6'd31:   c = armor6(lat[13:8]);
            6'd32:   c = armor6(lat[7:2]);
            6'd33:   c = armor6({lat[1:0], 4'b0000});
            6'd34:   c = armor6(6'd0);
            6'd35:   c = armor6({2'b00, hdg[8:5]});
            6'd36:   c = armor6({hdg[4:0], 1'b0});
            6'd37:   c = armor6(6'd0);
            default: c = TEMPLATE[8*(SENT_LEN-1-int'(idx)) +: 8];
        endcase
        return c;
    endfunction

endpackage

// File: design/aispse_if.sv
// ----------------------------------------------------------------------------
// aispse_if - channel interfaces of the AIS position sentence encoder
// Position item channel and sentence character channel, valid/ready.
// ----------------------------------------------------------------------------
interface aispse_pos_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [aispse_pkg::LAT_W-1:0]     latitude;
    logic signed [aispse_pkg::LON_W-1:0]     longitude;
    logic        [aispse_pkg::HDG_W-1:0]     heading;
    logic                                    is_target;

    modport source (output valid, latitude, longitude, heading, is_target, input ready);
    modport sink   (input valid, latitude, longitude, heading, is_target, output ready);
endinterface

interface aispse_chr_if;
    logic                              valid;
    logic                              ready;
    logic [aispse_pkg::CHR_W-1:0]      character;
    logic                              last;

    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface

// File: design/aispse_cell.sv
// ----------------------------------------------------------------------------
// aispse_cell - one byte cell of the sentence chain
// Loads its byte on a new item, otherwise takes its neighbour's byte on shift.
// ----------------------------------------------------------------------------
module aispse_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_shift,
    input  aispse_pkg::t_cell i_load_cell,
    input  aispse_pkg::t_cell i_next,
    output aispse_pkg::t_cell o_cell
);

    logic                         r_vld;
    aispse_pkg::t_kind            r_kind;
    logic [aispse_pkg::CHR_W-1:0] r_chr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_load_cell.vld;
        end else if (i_shift) begin
            r_vld <= i_next.vld;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_load_cell.kind;
            r_chr  <= i_load_cell.chr;
        end else if (i_shift) begin
            r_kind <= i_next.kind;
            r_chr  <= i_next.chr;
        end
    end

    assign o_cell = '{vld: r_vld, kind: r_kind, chr: r_chr};

endmodule

// File: design/ais_position_sentence_encoder_top.sv
// ----------------------------------------------------------------------------
// ais_position_sentence_encoder_top - AIS type 1 !AIVDM sentence encoder
// Turns one position item into a 48-byte NMEA sentence, one byte per item out.
// ----------------------------------------------------------------------------
// Each accepted position item (latitude and longitude in 1/10000 minute,
// heading in degrees, target flag) produces exactly 48 output items: the
// ASCII sentence "!AIVDM,1,1,,A,<28 payload chars>,0*HH" and a line feed,
// with last set on the line feed. The sentence is held in a chain of 48
// byte cells that are all loaded together and shift one place towards
// the output head per taken byte, so an item lasts as long as the sink
// takes to accept all 48 of its bytes. The next position item is accepted
// while the line feed of the previous sentence is still at the head, so
// sentences follow one another with no gap. The checksum is the XOR of
// bytes 1 to 43, gathered as those bytes leave the head, and put out as
// two uppercase hex digits. Position and heading bits are packed as they
// come, with no range check.
// ----------------------------------------------------------------------------
module ais_position_sentence_encoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    aispse_pos_if.sink           i_pos,
    aispse_chr_if.source         o_chr
);

    localparam int NCELL = aispse_pkg::SENT_LEN;

    // chain contents, cell 0 is the output head
    aispse_pkg::t_cell w_cell [NCELL];
    aispse_pkg::t_cell w_load_cell [NCELL];

    logic w_adv;      // head may advance this cycle
    logic w_load;     // new item taken, load every cell
    logic w_out_fire; // head byte taken by the sink

    logic [aispse_pkg::CHR_W-1:0] r_chk;
    logic [aispse_pkg::CHR_W-1:0] n_chk;
    logic [aispse_pkg::CHR_W-1:0] w_head_chr;

    // Advance whenever the head is empty or its byte is being taken.
    assign w_adv      = !w_cell[0].vld || o_chr.ready;
    // Take a new item once only the head (the line feed) at most remains
    // and it is leaving now.
    assign i_pos.ready = !w_cell[1].vld && w_adv;
    assign w_load     = i_pos.valid && i_pos.ready;
    assign w_out_fire = w_cell[0].vld && o_chr.ready;

    // Build the chain: each cell loads its own sentence byte and otherwise
    // takes the byte from the cell behind it.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        aispse_pkg::t_cell w_next;

        assign w_load_cell[g] = '{
            vld:  1'b1,
            kind: aispse_pkg::kind_of(aispse_pkg::POS_W'(g)),
            chr:  aispse_pkg::load_char(aispse_pkg::POS_W'(g),
                                        i_pos.latitude, i_pos.longitude,
                                        i_pos.heading, i_pos.is_target)
        };

        if (g == NCELL - 1) begin : g_tail
            // nothing behind the tail cell: shift in an empty slot
            assign w_next = '{vld: 1'b0, kind: aispse_pkg::K_PLAIN, chr: '0};
        end else begin : g_body
            assign w_next = w_cell[g+1];
        end

        aispse_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_load),
            .i_shift     (w_adv),
            .i_load_cell (w_load_cell[g]),
            .i_next      (w_next),
            .o_cell      (w_cell[g])
        );
    end

    // Running checksum: clear on a new sentence, fold in each checksummed
    // byte as it leaves. A load only happens with the line feed or nothing
    // at the head, so the two never coincide with a checksummed byte.
    always_comb begin
        n_chk = r_chk;
        priority if (w_load) begin
            n_chk = '0;
        end else if (w_out_fire && (w_cell[0].kind == aispse_pkg::K_SUM)) begin
            n_chk = r_chk ^ w_cell[0].chr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= '0;
        end else begin
            r_chk <= n_chk;
        end
    end

    // Head byte, with the hex digits of the checksum substituted in place.
    always_comb begin
        unique case (w_cell[0].kind)
            aispse_pkg::K_HEX_HI: w_head_chr = aispse_pkg::hex_digit(r_chk[7:4]);
            aispse_pkg::K_HEX_LO: w_head_chr = aispse_pkg::hex_digit(r_chk[3:0]);
            default:              w_head_chr = w_cell[0].chr;
        endcase
    end

    assign o_chr.valid     = w_cell[0].vld;
    assign o_chr.character = w_head_chr;
    assign o_chr.last      = (w_cell[0].kind == aispse_pkg::K_LAST);

    // A new sentence is loaded only behind an empty head or a line feed.
    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!w_cell[0].vld || (w_cell[0].kind == aispse_pkg::K_LAST)))
        else $error("sentence loaded over unsent bytes");

    // A loaded sentence starts with '!' at the head.
    a_head_bang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (w_cell[0].vld && (w_cell[0].chr == aispse_pkg::CHR_BANG)))
        else $error("sentence does not start with the start delimiter");

    // Valid bytes stay packed against the head.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[1].vld |-> w_cell[0].vld)
        else $error("gap at the head of the byte chain");

endmodule
